// ----- hw/rtl/ptb_pkg.sv -----
// shared constants and types for the periodic timer bank
package ptb_pkg;

  localparam int unsigned NumTimersDefault = 64;
  localparam int unsigned TickMsDefault    = 20;
  localparam int unsigned SlotW            = 6;

  localparam logic [31:0] MarkCanceled  = 32'hffff_fff5;
  localparam logic [31:0] MarkConnected = 32'hffff_fff4;
  localparam logic [31:0] MarkCreated   = 32'hffff_fff3;
  localparam logic [31:0] MarkDeleted   = 32'hffff_fff2;
  localparam logic [31:0] MarkDisarmed  = 32'hffff_fff0;
  localparam logic [30:0] MinMs         = 31'd1000;

  typedef enum logic [2:0] {
    CmdCreate  = 3'd0,
    CmdConnect = 3'd1,
    CmdSettime = 3'd2,
    CmdCancel  = 3'd3,
    CmdDelete  = 3'd4,
    CmdGettime = 3'd5,
    CmdTick    = 3'd6,
    CmdElapsed = 3'd7
  } cmd_e;

  // one slot entry of the store
  typedef struct packed {
    logic [31:0] count;
    logic [31:0] period;
    logic [7:0]  handler;
    logic [31:0] arg;
  } entry_t;

  // write request from the controller to the store
  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] addr;
    entry_t           data;
  } wr_req_t;

endpackage

// ----- hw/rtl/ptb_store.sv -----
// slot store: one synchronous memory, one read and one write port
module ptb_store #(
  parameter int unsigned NumTimers = ptb_pkg::NumTimersDefault
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [ptb_pkg::SlotW-1:0]  rd_addr_i,
  output ptb_pkg::entry_t            rd_data_o,
  input  ptb_pkg::wr_req_t           wr_i
);

  ptb_pkg::entry_t mem_q [NumTimers];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr[$clog2(NumTimers)-1:0]] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i[$clog2(NumTimers)-1:0]];
    end
  end

endmodule

// ----- hw/rtl/ptb_div.sv -----
// reciprocal divider of a 31-bit value by the tick length
module ptb_div #(
  parameter int unsigned TickMs = ptb_pkg::TickMsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [30:0] num_i,
  output logic        done_o,
  output logic [30:0] quot_o
);

  localparam logic [30:0] Divisor = 31'(TickMs);
  localparam logic [31:0] Recip   = 32'(32'hffff_ffff / TickMs);

  logic [62:0] prod_d, prod_q;
  logic [30:0] num_q, est_d, est_q, back_d, back_q, rem;
  logic        s1_q, s2_q;

  // estimate is at most one below the true quotient
  assign prod_d = 63'(num_i) * 63'(Recip);
  assign est_d  = prod_q[62:32];
  assign back_d = est_d * Divisor;
  assign rem    = num_q - back_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_o <= 1'b0;
    end else begin
      s1_q   <= start_i;
      s2_q   <= s1_q;
      done_o <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      prod_q <= prod_d;
    end
    if (s1_q) begin
      est_q  <= est_d;
      back_q <= back_d;
    end
    if (s2_q) begin
      quot_o <= est_q + 31'(rem >= Divisor);
    end
  end

endmodule

// ----- hw/rtl/periodic_timer_bank_top.sv -----
// periodic timer bank top level: command decode, slot walk and result drive
//
// usage: a request is taken at a clock edge with start high and busy low.
// every command gives one result with last_o set, marked by valid_o for one
// cycle; tick gives one result per expired slot and then a closing result.
// the receiver cannot stall: results go out as they are made.
// sequence: connect, cancel, delete, gettime and elapsed read their slot
// when the request is taken and give their result from StExec; settime,
// when it divides, runs the divider for the value, then for the interval,
// and gives its result when the second is done; create and tick walk the
// slot memory one slot at a time (read, then write back), paced by the
// memory's single read port. busy stays high from acceptance until the
// last result has gone out and any store write has landed, so a request
// that writes the store holds the next one off past its own result.
// reset: after reset the block sweeps the memory, one slot a cycle, writing
// the deleted state into all NumTimers entries; busy is high meanwhile,
// so no request is taken until the sweep and its last write are done.
// the tick counter is cleared by reset directly.
module periodic_timer_bank_top #(
  parameter int unsigned NumTimers = ptb_pkg::NumTimersDefault,
  parameter int unsigned TickMs    = ptb_pkg::TickMsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd_i,
  input  logic [5:0]  slot_i,
  input  logic [7:0]  handler_id_i,
  input  logic signed [31:0] arg_value_i,
  input  logic        mode_flags_i,
  input  logic [30:0] value_ms_i,
  input  logic [30:0] interval_ms_i,
  input  logic [31:0] base_ms_i,
  output logic        valid_o,
  output logic        status_o,
  output logic [5:0]  slot_out_o,
  output logic [30:0] remaining_ms_o,
  output logic [31:0] elapsed_ms_o,
  output logic        fired_o,
  output logic [7:0]  fired_handler_o,
  output logic signed [31:0] fired_arg_o,
  output logic        last_o
);

  localparam int unsigned SlotW = ptb_pkg::SlotW;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(NumTimers - 1);

  typedef enum logic [3:0] {
    StClear, StIdle, StRead, StExec, StDivV, StDivI, StWalkRd, StWalkEx, StClose
  } state_e;

  state_e            state_q;
  ptb_pkg::cmd_e     cmd_q;
  logic [SlotW-1:0]  slot_q, walk_q;
  logic [7:0]        hid_q;
  logic [31:0]       arg_q, base_q, tick_q;
  logic              flag_q;
  logic [30:0]       val_q, ivl_q;
  logic [31:0]       cnt_div_q;

  logic              rd_en;
  logic [SlotW-1:0]  rd_addr;
  ptb_pkg::entry_t   rd_data, e;
  ptb_pkg::wr_req_t  wr;

  logic              div_start, div_done;
  logic [30:0]       div_num, div_quot;

  logic              slot_ok, accept;
  logic [31:0]       dec, tms, elap;
  logic [36:0]       rem_full;

  ptb_store #(.NumTimers(NumTimers)) u_store (
    .clk_i, .rd_en_i(rd_en), .rd_addr_i(rd_addr), .rd_data_o(rd_data), .wr_i(wr)
  );

  ptb_div #(.TickMs(TickMs)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
    .done_o(div_done), .quot_o(div_quot)
  );

  assign e       = rd_data;
  assign slot_ok = (slot_q != '0) && (slot_q <= LastSlot);
  assign dec     = e.count - 32'd1;
  assign rem_full = 37'(e.count) * 37'(TickMs);
  assign tms     = 32'(tick_q * 32'(TickMs));
  assign elap    = (tms > base_q) ? tms - base_q : tms + (32'hffff_ffff - base_q);
  // a pending store write holds off the next request
  assign busy    = (state_q != StIdle) || wr.en;
  assign accept  = start && !busy;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = slot_q;
    if (accept && cmd_i != ptb_pkg::CmdTick && cmd_i != ptb_pkg::CmdCreate) begin
      rd_en   = 1'b1;
      rd_addr = slot_i;
    end else if (state_q == StWalkRd) begin
      rd_en   = 1'b1;
      rd_addr = walk_q;
    end else if (accept) begin
      rd_en   = 1'b1;
      rd_addr = SlotW'(1);
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = (val_q < ptb_pkg::MinMs) ? ptb_pkg::MinMs : val_q;
    if (state_q == StExec && cmd_q == ptb_pkg::CmdSettime && slot_ok && !flag_q
        && e.handler != 8'd0) begin
      div_start = 1'b1;
    end else if (state_q == StDivV && div_done) begin
      div_start = 1'b1;
      div_num   = (ivl_q < ptb_pkg::MinMs) ? ptb_pkg::MinMs : ivl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      walk_q  <= '0;
      tick_q  <= '0;
      valid_o <= 1'b0;
      wr.en   <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      wr.en   <= 1'b0;
      status_o <= 1'b0; slot_out_o <= '0; remaining_ms_o <= '0; elapsed_ms_o <= '0;
      fired_o <= 1'b0; fired_handler_o <= '0; fired_arg_o <= '0; last_o <= 1'b0;
      unique case (state_q)
        StClear: begin
          wr.en   <= 1'b1;
          wr.addr <= walk_q;
          wr.data <= '{ptb_pkg::MarkDeleted, ptb_pkg::MarkDisarmed, 8'd0, 32'd0};
          walk_q  <= walk_q + SlotW'(1);
          if (walk_q == LastSlot) state_q <= StIdle;
        end
        StIdle: begin
          if (accept) begin
            cmd_q  <= ptb_pkg::cmd_e'(cmd_i);
            slot_q <= slot_i; hid_q <= handler_id_i; arg_q <= arg_value_i;
            flag_q <= mode_flags_i; val_q <= value_ms_i; ivl_q <= interval_ms_i;
            base_q <= base_ms_i;
            walk_q <= SlotW'(1);
            if (cmd_i == ptb_pkg::CmdTick) begin
              tick_q  <= tick_q + 32'd1;
              state_q <= StWalkEx;
            end else if (cmd_i == ptb_pkg::CmdCreate) begin
              state_q <= StWalkEx;
            end else begin
              state_q <= StExec;
            end
          end
        end
        StExec: begin
          wr.addr <= slot_q;
          wr.data <= e;
          last_o  <= 1'b1;
          valid_o <= 1'b1;
          state_q <= StIdle;
          unique case (cmd_q)
            ptb_pkg::CmdElapsed: elapsed_ms_o <= elap;
            ptb_pkg::CmdSettime: begin
              if (slot_ok && !flag_q && e.handler != 8'd0) begin
                valid_o <= 1'b0;
                state_q <= StDivV;
              end else status_o <= 1'b1;
            end
            default: begin
              if (!slot_ok) status_o <= 1'b1;
              else begin
                unique case (cmd_q)
                  ptb_pkg::CmdConnect: begin
                    wr.en <= 1'b1;
                    wr.data <= '{ptb_pkg::MarkConnected, e.period, hid_q, arg_q};
                  end
                  ptb_pkg::CmdCancel: begin
                    wr.en <= 1'b1;
                    wr.data <= '{ptb_pkg::MarkCanceled, e.period, e.handler, e.arg};
                  end
                  ptb_pkg::CmdDelete: begin
                    wr.en <= 1'b1;
                    wr.data <= '{ptb_pkg::MarkDeleted, e.period, 8'd0, 32'd0};
                  end
                  default: begin
                    if (!e.count[31])
                      remaining_ms_o <= (rem_full > 37'h7fff_ffff) ? 31'h7fff_ffff
                                                                   : rem_full[30:0];
                  end
                endcase
              end
            end
          endcase
        end
        StDivV: begin
          if (div_done) begin
            cnt_div_q <= {1'b0, div_quot};
            state_q   <= StDivI;
          end
        end
        StDivI: begin
          if (div_done) begin
            wr.en   <= 1'b1;
            wr.data <= '{cnt_div_q, (ivl_q == '0) ? ptb_pkg::MarkDisarmed
                                                  : {1'b0, div_quot}, e.handler, e.arg};
            valid_o <= 1'b1;
            last_o  <= 1'b1;
            state_q <= StIdle;
          end
        end
        StWalkRd: state_q <= StWalkEx;
        StWalkEx: begin
          wr.addr <= walk_q;
          state_q <= StWalkRd;
          walk_q  <= walk_q + SlotW'(1);
          if (walk_q == LastSlot) state_q <= StClose;
          if (cmd_q == ptb_pkg::CmdCreate) begin
            if (e.count == ptb_pkg::MarkDeleted) begin
              wr.en   <= 1'b1;
              wr.data <= '{ptb_pkg::MarkCreated, e.period, 8'd0, 32'd0};
              valid_o <= 1'b1; last_o <= 1'b1; slot_out_o <= walk_q;
              state_q <= StIdle;
            end
          end else if (!e.count[31]) begin
            wr.en   <= 1'b1;
            wr.data <= '{(dec == '0) ? e.period : dec, e.period, e.handler, e.arg};
            if (dec == '0) begin
              valid_o <= 1'b1; fired_o <= 1'b1; slot_out_o <= walk_q;
              fired_handler_o <= e.handler; fired_arg_o <= e.arg;
            end
          end
        end
        StClose: begin
          valid_o <= 1'b1; last_o <= 1'b1;
          status_o <= (cmd_q == ptb_pkg::CmdCreate);
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // a fired result that is not the last one only appears while the block is busy
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> busy) else $error("fire item outside a walk");
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q == StIdle) && state_q == StIdle |-> !wr.en)
    else $error("store written while idle");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |-> state_q == StIdle) else $error("last result but still busy");

endmodule
